/* hw/rtl/srtf_pkg.sv */
// Shared types and constants of the shortest-remaining-time-first tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic CFG_IDX_PROCESS_COUNT = 1'b0;
  localparam logic [4:0] PROC_COUNT_RESET = 5'd1;

  typedef struct packed {
    logic        action;
    logic [3:0]  slot;
    logic [15:0] burst_time;
    logic [15:0] arrival_time;
  } in_word_t;

  typedef struct packed {
    logic [31:0] tick_time;
    logic [3:0]  running_slot;
    logic        idle;
    logic        completed;
    logic [31:0] wait_time;
    logic [31:0] turnaround_time;
  } out_word_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] arr;
    logic [15:0] burst;
  } proc_ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/srtf_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/srtf_tick_scheduler.sv */
// Top level of the shortest-remaining-time-first tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

// A load word writes one slot and the next word may follow at once.
// A tick word walks the slots in use one per cycle through a single compare unit,
// reading burst/arrival/remaining and wait entries from two RAMs, then, in the
// write-back state, writes back the chosen slot and forms the result. The input is
// stalled from the accept of a tick until the write-back is done; the result
// sits in an output register, and write-back waits only while that register is
// full and out_stall is high. Wait counts of waiting slots are bumped during the walk itself.
// There is no clearing pass: slots are pending only after a load.

module srtf_tick_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire srtf_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output srtf_pkg::out_word_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int EW = $bits(srtf_pkg::proc_ent_t);

  srtf_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  srtf_pkg::proc_ent_t best_ent_r, best_ent_nxt;
  logic [31:0]         best_wait_r, best_wait_nxt;
  logic [31:0]         current_tick_r, current_tick_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt;
  logic [4:0]          pc_r, pc_nxt;
  logic                out_valid_r, out_valid_nxt;
  srtf_pkg::out_word_t out_r, out_nxt;

  logic                ent_we;
  logic [AW-1:0]       ent_waddr;
  srtf_pkg::proc_ent_t ent_wdata;
  srtf_pkg::proc_ent_t ent_rd;
  logic                wt_we;
  logic [AW-1:0]       wt_waddr;
  logic [31:0]         wt_wdata;
  logic [31:0]         wt_rd;
  logic [AW-1:0]       raddr;

  logic                in_acc;
  logic                cfg_wr;
  logic [6:0]          slot_w;
  logic [6:0]          pc_w;
  logic [6:0]          cnt7;
  logic [6:0]          best_idx_w;
  logic                elig;
  logic                go;
  logic [15:0]         rem_dec;
  logic                fin;
  logic [32:0]         tat_sum;

  srtf_ram #(.WIDTH(EW), .DEPTH(MAX_PROCS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (raddr),
    .rdata (ent_rd)
  );

  srtf_ram #(.WIDTH(32), .DEPTH(MAX_PROCS)) u_wait_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (raddr),
    .rdata (wt_rd)
  );

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == srtf_pkg::CFG_IDX_PROCESS_COUNT) ? {27'd0, pc_r} : 32'd0;
  assign in_stall  = (state_r != srtf_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slot_w     = {3'd0, in_data.slot};
  assign pc_w       = {2'd0, pc_r};
  assign cnt7       = (pc_w > 7'(MAX_PROCS)) ? 7'(MAX_PROCS) : pc_w;
  assign best_idx_w = 7'(best_idx_r);
  assign raddr      = rd_idx_r[AW-1:0];
  assign elig       = chk_vld_r && !done_r[chk_idx_r] &&
                      ({16'd0, ent_rd.arr} <= current_tick_r);
  assign go         = !out_valid_r || !out_stall;
  assign rem_dec    = best_ent_r.rem - 16'd1;
  assign fin        = found_r && (rem_dec == 16'd0);
  assign tat_sum    = {1'b0, best_wait_r} + {17'd0, best_ent_r.burst};

  always_comb begin
    state_nxt        = state_r;
    rd_idx_nxt       = rd_idx_r;
    cnt_nxt          = cnt_r;
    chk_vld_nxt      = 1'b0;
    chk_idx_nxt      = chk_idx_r;
    found_nxt        = found_r;
    best_idx_nxt     = best_idx_r;
    best_ent_nxt     = best_ent_r;
    best_wait_nxt    = best_wait_r;
    current_tick_nxt = current_tick_r;
    done_nxt         = done_r;
    pc_nxt           = pc_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_nxt          = out_r;
    ent_we           = 1'b0;
    ent_waddr        = best_idx_r;
    ent_wdata        = best_ent_r;
    wt_we            = 1'b0;
    wt_waddr         = chk_idx_r;
    wt_wdata         = (wt_rd == 32'hFFFF_FFFF) ? wt_rd : wt_rd + 32'd1;

    if (cfg_wr && paddr[2] == srtf_pkg::CFG_IDX_PROCESS_COUNT) begin
      pc_nxt = pwdata[4:0];
    end

    unique case (state_r)
      srtf_pkg::ST_IDLE: begin
        if (in_acc && in_data.action == srtf_pkg::ACT_LOAD) begin
          if (slot_w < 7'(MAX_PROCS)) begin
            ent_we          = 1'b1;
            ent_waddr       = slot_w[AW-1:0];
            ent_wdata.rem   = in_data.burst_time;
            ent_wdata.arr   = in_data.arrival_time;
            ent_wdata.burst = in_data.burst_time;
            wt_we           = 1'b1;
            wt_waddr        = slot_w[AW-1:0];
            wt_wdata        = 32'd0;
            done_nxt[slot_w[AW-1:0]] = (in_data.burst_time == 16'd0);
          end
        end else if (in_acc) begin
          state_nxt  = srtf_pkg::ST_SCAN;
          rd_idx_nxt = '0;
          cnt_nxt    = CW'(cnt7);
          found_nxt  = 1'b0;
        end
      end
      srtf_pkg::ST_SCAN: begin
        if (rd_idx_r != cnt_r) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[AW-1:0];
        end else begin
          state_nxt = srtf_pkg::ST_FIN;
        end
        if (elig) begin
          wt_we = 1'b1;
          if (!found_r || ent_rd.rem < best_ent_r.rem) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = chk_idx_r;
            best_ent_nxt  = ent_rd;
            best_wait_nxt = wt_rd;
          end
        end
      end
      srtf_pkg::ST_FIN: begin
        if (go) begin
          state_nxt = srtf_pkg::ST_IDLE;
          if (found_r) begin
            ent_we        = 1'b1;
            ent_wdata.rem = rem_dec;
            // undo the bump the running slot got during the walk
            wt_we         = 1'b1;
            wt_waddr      = best_idx_r;
            wt_wdata      = best_wait_r;
          end
          if (fin) begin
            done_nxt[best_idx_r] = 1'b1;
          end
          out_valid_nxt           = 1'b1;
          out_nxt.tick_time       = current_tick_r;
          out_nxt.running_slot    = found_r ? best_idx_w[3:0] : 4'd0;
          out_nxt.idle            = !found_r;
          out_nxt.completed       = fin;
          out_nxt.wait_time       = fin ? best_wait_r : 32'd0;
          out_nxt.turnaround_time = !fin ? 32'd0 :
                                    (tat_sum[32] ? 32'hFFFF_FFFF : tat_sum[31:0]);
          current_tick_nxt = (current_tick_r == 32'hFFFF_FFFF) ?
                             current_tick_r : current_tick_r + 32'd1;
        end
      end
      default: begin
        state_nxt = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= srtf_pkg::ST_IDLE;
      rd_idx_r       <= '0;
      cnt_r          <= '0;
      chk_vld_r      <= 1'b0;
      found_r        <= 1'b0;
      current_tick_r <= 32'd0;
      done_r         <= '1;
      pc_r           <= srtf_pkg::PROC_COUNT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rd_idx_r       <= rd_idx_nxt;
      cnt_r          <= cnt_nxt;
      chk_vld_r      <= chk_vld_nxt;
      found_r        <= found_nxt;
      current_tick_r <= current_tick_nxt;
      done_r         <= done_nxt;
      pc_r           <= pc_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r   <= chk_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_ent_r  <= best_ent_nxt;
    best_wait_r <= best_wait_nxt;
    out_r       <= out_nxt;
  end

  a_rose_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == srtf_pkg::ST_FIN))
    else $error("result raised outside write-back");

  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.completed |-> !out_r.idle)
    else $error("completion reported on idle tick");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srtf_pkg::ST_SCAN |-> rd_idx_r <= cnt_r)
    else $error("scan index past slot count");

  a_tick_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> current_tick_r >= $past(current_tick_r))
    else $error("tick counter went backward");

  a_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srtf_pkg::ST_SCAN && $past(state_r == srtf_pkg::ST_IDLE) |->
    $past(in_valid) && $past(in_data.action == srtf_pkg::ACT_TICK))
    else $error("scan started without a tick word");

endmodule

`default_nettype wire
